// ----- design/vove_pkg.sv -----
package vove_pkg;

    localparam int HISTORY_DEPTH_DEF = 7;
    localparam int POSITION_BITS_DEF = 12;
    localparam int MAX_POINTS        = 7;

    localparam int CNT_W      = 3;
    localparam int FR_W       = 8;
    localparam int VEL_W      = 29;
    localparam int COEF_W     = 10;
    localparam int LOOP_W     = 3;
    localparam int PC_W       = 3;
    localparam int RADIX_BITS = 8;   // quotient bits per divide step
    localparam int DIVISOR_W  = 4;
    localparam int REM_W      = 5;
    localparam int SHIFT_W    = 3;
    localparam int ADDEND_W   = 3;

    localparam logic [FR_W-1:0] FR_RESET = 8'd30;

    // datapath operations, one per microcode word
    typedef enum logic [2:0] {
        OP_WAIT  = 3'd0,
        OP_MAC   = 3'd1,
        OP_SCALE = 3'd2,
        OP_LOAD  = 3'd3,
        OP_DIV   = 3'd4,
        OP_OUT   = 3'd5
    } op_t;

    // jump conditions: when the condition holds the sequencer takes jump_pc
    typedef enum logic [1:0] {
        COND_NONE = 2'd0,
        COND_IN   = 2'd1,   // no input beat offered
        COND_LOOP = 2'd2,   // loop counter not at its last value
        COND_OUT  = 2'd3    // output register still occupied
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] jump_pc;
        logic [PC_W-1:0] next_pc;
    } uword_t;

    typedef struct packed {
        op_t              op;
        logic [LOOP_W-1:0] step;
        logic [CNT_W-1:0] points;
        logic             push;
    } lane_ctrl_t;

    // rounding scale of mag by 16/D folded into (mag << shift + addend) / divisor
    typedef struct packed {
        logic [SHIFT_W-1:0]   shift;
        logic [ADDEND_W-1:0]  addend;
        logic [DIVISOR_W-1:0] divisor;
    } round_t;

    localparam logic [PC_W-1:0] PC_WAIT  = 3'd0;
    localparam logic [PC_W-1:0] PC_MAC   = 3'd1;
    localparam logic [PC_W-1:0] PC_SCALE = 3'd2;
    localparam logic [PC_W-1:0] PC_LOAD  = 3'd3;
    localparam logic [PC_W-1:0] PC_DIV   = 3'd4;
    localparam logic [PC_W-1:0] PC_OUT   = 3'd5;

    // backward-difference weights, row = points held, column = age (0 newest)
    localparam logic signed [COEF_W-1:0] COEF_TABLE [MAX_POINTS+1][MAX_POINTS] = '{
        '{10'sd0,   10'sd0,    10'sd0,   10'sd0,    10'sd0,   10'sd0,   10'sd0},
        '{10'sd0,   10'sd0,    10'sd0,   10'sd0,    10'sd0,   10'sd0,   10'sd0},
        '{10'sd1,   -10'sd1,   10'sd0,   10'sd0,    10'sd0,   10'sd0,   10'sd0},
        '{10'sd3,   -10'sd4,   10'sd1,   10'sd0,    10'sd0,   10'sd0,   10'sd0},
        '{10'sd11,  -10'sd18,  10'sd9,   -10'sd2,   10'sd0,   10'sd0,   10'sd0},
        '{10'sd25,  -10'sd48,  10'sd36,  -10'sd16,  10'sd3,   10'sd0,   10'sd0},
        '{10'sd137, -10'sd300, 10'sd300, -10'sd200, 10'sd75,  -10'sd12, 10'sd0},
        '{10'sd147, -10'sd360, 10'sd450, -10'sd400, 10'sd225, -10'sd72, 10'sd10}
    };

    function automatic logic signed [COEF_W-1:0] coef_f(input logic [CNT_W-1:0] n,
                                                        input logic [LOOP_W-1:0] i);
        logic signed [COEF_W-1:0] c;
        c = '0;
        if (i < LOOP_W'(MAX_POINTS)) begin
            c = COEF_TABLE[n][i];
        end
        return c;
    endfunction

    // D = 1,2,6,12,60,60 for 2..7 points; rows below two give a zero sum anyway
    function automatic round_t round_f(input logic [CNT_W-1:0] n);
        round_t r;
        unique case (n) inside
            3'd3:       r = '{shift: 3'd3, addend: 3'd0, divisor: 4'd1};
            3'd4:       r = '{shift: 3'd3, addend: 3'd1, divisor: 4'd3};
            3'd5:       r = '{shift: 3'd2, addend: 3'd1, divisor: 4'd3};
            3'd6, 3'd7: r = '{shift: 3'd2, addend: 3'd7, divisor: 4'd15};
            default:    r = '{shift: 3'd4, addend: 3'd0, divisor: 4'd1};
        endcase
        return r;
    endfunction

    // dividend is position + 22 bits wide; divide steps cover it in radix-256 digits
    function automatic int div_steps(input int pos_bits);
        return (pos_bits + 22 + RADIX_BITS - 1) / RADIX_BITS;
    endfunction

    function automatic uword_t ucode(input logic [PC_W-1:0] pc);
        uword_t w;
        unique case (pc)
            PC_WAIT:  w = '{op: OP_WAIT,  cond: COND_IN,   jump_pc: PC_WAIT, next_pc: PC_MAC};
            PC_MAC:   w = '{op: OP_MAC,   cond: COND_LOOP, jump_pc: PC_MAC,  next_pc: PC_SCALE};
            PC_SCALE: w = '{op: OP_SCALE, cond: COND_NONE, jump_pc: PC_WAIT, next_pc: PC_LOAD};
            PC_LOAD:  w = '{op: OP_LOAD,  cond: COND_NONE, jump_pc: PC_WAIT, next_pc: PC_DIV};
            PC_DIV:   w = '{op: OP_DIV,   cond: COND_LOOP, jump_pc: PC_DIV,  next_pc: PC_OUT};
            PC_OUT:   w = '{op: OP_OUT,   cond: COND_OUT,  jump_pc: PC_OUT,  next_pc: PC_WAIT};
            default:  w = '{op: OP_WAIT,  cond: COND_NONE, jump_pc: PC_WAIT, next_pc: PC_WAIT};
        endcase
        return w;
    endfunction

endpackage

// ----- design/variable_order_velocity_estimator.sv -----
// A beat is taken only in the WAIT step; the next beat is not taken until the multiply-accumulate
// loop over the history taps and the radix-256 divide loop have run and the result is loaded.
// A finished result sits in the output register while the next beat is taken.
// Reset (aresetn, synchronous, active low): history empty, frame_rate 30, no result pending.
module variable_order_velocity_estimator #(
    parameter int HISTORY_DEPTH = vove_pkg::HISTORY_DEPTH_DEF,
    parameter int POSITION_BITS = vove_pkg::POSITION_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [vove_pkg::FR_W-1:0]         cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [POSITION_BITS-1:0]   s_ball_x,
    input  logic signed [POSITION_BITS-1:0]   s_ball_y,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [vove_pkg::VEL_W-1:0] m_vel_x,
    output logic signed [vove_pkg::VEL_W-1:0] m_vel_y,
    output logic [vove_pkg::CNT_W-1:0]        m_points_used
);
    import vove_pkg::*;

    // last loop counter value of each looping microcode step
    localparam logic [LOOP_W-1:0] MAC_LAST = LOOP_W'(HISTORY_DEPTH - 1);
    localparam logic [LOOP_W-1:0] DIV_LAST = LOOP_W'(div_steps(POSITION_BITS) - 1);

    logic [PC_W-1:0]   pc_reg, pc_next;
    logic [LOOP_W-1:0] loop_reg, loop_next, loop_last;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [FR_W-1:0]   frame_rate_reg;
    logic              m_valid_reg, m_valid_next;
    logic signed [VEL_W-1:0] vel_x_reg, vel_y_reg, lane_vel_x, lane_vel_y;
    logic [CNT_W-1:0]  points_reg;

    uword_t     uw;
    lane_ctrl_t ctrl;
    logic       hold;
    logic       in_fire;
    logic       lost;
    logic       out_fire;

    // ---------------------------------------------------------------
    // Microcode sequencer: the program is
    //   WAIT  - take a beat, update history and count
    //   MAC   - weighted sum, one history tap per cycle
    //   SCALE - |sum| * frame_rate
    //   LOAD  - fold rounding into the dividend
    //   DIV   - one quotient byte per cycle
    //   OUT   - load output register once it is free
    // ---------------------------------------------------------------
    assign uw = ucode(pc_reg);

    always_comb begin
        loop_last = (uw.op == OP_DIV) ? DIV_LAST : MAC_LAST;
        unique case (uw.cond)
            COND_NONE: hold = 1'b0;
            COND_IN:   hold = !s_valid;
            COND_LOOP: hold = (loop_reg != loop_last);
            COND_OUT:  hold = m_valid_reg && !m_ready;
            default:   hold = 1'b0;
        endcase
        pc_next = hold ? uw.jump_pc : uw.next_pc;
        // loop counter runs only while a loop step repeats, else it is parked at zero
        if (uw.cond == COND_LOOP && hold) begin
            loop_next = loop_reg + 1'b1;
        end else begin
            loop_next = '0;
        end
    end

    // input side
    assign s_ready = (uw.op == OP_WAIT);
    assign in_fire = s_valid && s_ready;
    // a negative coordinate means the tracker lost the ball
    assign lost    = s_ball_x[POSITION_BITS-1] || s_ball_y[POSITION_BITS-1];

    always_comb begin
        count_next = count_reg;
        if (in_fire) begin
            if (lost) begin
                count_next = '0;
            end else if (count_reg < CNT_W'(HISTORY_DEPTH)) begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    // lost ball: history is left alone, count zero selects the all-zero weights
    assign ctrl = '{op: uw.op, step: loop_reg, points: count_reg, push: in_fire && !lost};

    vove_lane #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .POSITION_BITS (POSITION_BITS)
    ) u_lane_x (
        .aclk       (aclk),
        .ctrl       (ctrl),
        .pos        (s_ball_x),
        .frame_rate (frame_rate_reg),
        .vel        (lane_vel_x)
    );

    vove_lane #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .POSITION_BITS (POSITION_BITS)
    ) u_lane_y (
        .aclk       (aclk),
        .ctrl       (ctrl),
        .pos        (s_ball_y),
        .frame_rate (frame_rate_reg),
        .vel        (lane_vel_y)
    );

    // output register
    assign out_fire     = (uw.op == OP_OUT) && !hold;
    assign m_valid_next = out_fire || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg         <= PC_WAIT;
            loop_reg       <= '0;
            count_reg      <= '0;
            m_valid_reg    <= 1'b0;
            frame_rate_reg <= FR_RESET;
        end else begin
            pc_reg      <= pc_next;
            loop_reg    <= loop_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                frame_rate_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_fire) begin
            vel_x_reg  <= lane_vel_x;
            vel_y_reg  <= lane_vel_y;
            points_reg <= count_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_vel_x       = vel_x_reg;
    assign m_vel_y       = vel_y_reg;
    assign m_points_used = points_reg;

endmodule

// ----- design/vove_lane.sv -----
module vove_lane #(
    parameter int HISTORY_DEPTH = vove_pkg::HISTORY_DEPTH_DEF,
    parameter int POSITION_BITS = vove_pkg::POSITION_BITS_DEF
) (
    input  logic                              aclk,
    input  vove_pkg::lane_ctrl_t              ctrl,
    input  logic signed [POSITION_BITS-1:0]   pos,
    input  logic [vove_pkg::FR_W-1:0]         frame_rate,
    output logic signed [vove_pkg::VEL_W-1:0] vel
);
    import vove_pkg::*;

    localparam int ABS_W  = POSITION_BITS + 10;
    localparam int ACC_W  = ABS_W + 1;
    localparam int PROD_W = COEF_W + POSITION_BITS;
    localparam int MAG_W  = ABS_W + FR_W;
    localparam int DIVW   = div_steps(POSITION_BITS) * RADIX_BITS;
    localparam logic [DIVW-1:0] SAT_POS = DIVW'(2**(VEL_W-1) - 1);
    localparam logic [DIVW-1:0] SAT_NEG = DIVW'(2**(VEL_W-1));

    logic signed [POSITION_BITS-1:0] hist_reg [HISTORY_DEPTH];
    logic signed [POSITION_BITS-1:0] tap;
    logic signed [COEF_W-1:0]        coef;
    logic signed [PROD_W-1:0]        prod;
    logic signed [ACC_W-1:0]         acc_reg, acc_next;
    logic                            sign_reg, sign_next;
    logic [ABS_W-1:0]                abs_val;
    logic [MAG_W-1:0]                mag_reg, mag_next;
    logic [DIVW-1:0]                 div_reg, div_next, div_step;
    logic [REM_W-1:0]                rem_reg, rem_next, rem_step;
    round_t                          rnd;

    // newest-first history line
    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            hist_reg[0] <= pos;
            for (int i = 1; i < HISTORY_DEPTH; i++) begin
                hist_reg[i] <= hist_reg[i-1];
            end
        end
    end

    // taps beyond the points held read as zero
    always_comb begin
        tap = '0;
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
            if (ctrl.step == LOOP_W'(i) && LOOP_W'(i) < ctrl.points) begin
                tap = hist_reg[i];
            end
        end
    end

    assign coef    = coef_f(ctrl.points, ctrl.step);
    assign prod    = coef * tap;
    assign rnd     = round_f(ctrl.points);
    assign abs_val = acc_reg[ACC_W-1] ? ABS_W'(-acc_reg) : ABS_W'(acc_reg);

    // one radix-256 digit of restoring division by a small constant
    always_comb begin : div_digit
        logic [DIVW-1:0]  d;
        logic [REM_W-1:0] r;
        logic [REM_W-1:0] t;
        d = div_reg;
        r = rem_reg;
        for (int b = 0; b < RADIX_BITS; b++) begin
            t = {r[REM_W-2:0], d[DIVW-1]};
            d = {d[DIVW-2:0], 1'b0};
            if (t >= REM_W'(rnd.divisor)) begin
                t    = t - REM_W'(rnd.divisor);
                d[0] = 1'b1;
            end
            r = t;
        end
        div_step = d;
        rem_step = r;
    end

    always_comb begin
        acc_next  = acc_reg;
        sign_next = sign_reg;
        mag_next  = mag_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        unique case (ctrl.op)
            OP_MAC: begin
                if (ctrl.step == '0) begin
                    acc_next = ACC_W'(prod);
                end else begin
                    acc_next = acc_reg + ACC_W'(prod);
                end
            end
            OP_SCALE: begin
                sign_next = acc_reg[ACC_W-1];
                mag_next  = MAG_W'(abs_val) * MAG_W'(frame_rate);
            end
            OP_LOAD: begin
                div_next = (DIVW'(mag_reg) << rnd.shift) + DIVW'(rnd.addend);
                rem_next = '0;
            end
            OP_DIV: begin
                div_next = div_step;
                rem_next = rem_step;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        acc_reg  <= acc_next;
        sign_reg <= sign_next;
        mag_reg  <= mag_next;
        div_reg  <= div_next;
        rem_reg  <= rem_next;
    end

    // saturate the magnitude and restore the sign
    always_comb begin
        if (!sign_reg) begin
            if (div_reg > SAT_POS) begin
                vel = {1'b0, {(VEL_W-1){1'b1}}};
            end else begin
                vel = div_reg[VEL_W-1:0];
            end
        end else begin
            if (div_reg > SAT_NEG) begin
                vel = {1'b1, {(VEL_W-1){1'b0}}};
            end else begin
                vel = -div_reg[VEL_W-1:0];
            end
        end
    end

endmodule

// ----- design/vove_chk.sv -----
module vove_chk #(
    parameter int HISTORY_DEPTH = vove_pkg::HISTORY_DEPTH_DEF,
    parameter int POSITION_BITS = vove_pkg::POSITION_BITS_DEF
) (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic signed [POSITION_BITS-1:0]   s_ball_x,
    input logic signed [POSITION_BITS-1:0]   s_ball_y,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic signed [vove_pkg::VEL_W-1:0] m_vel_x,
    input logic signed [vove_pkg::VEL_W-1:0] m_vel_y,
    input logic [vove_pkg::CNT_W-1:0]        m_points_used
);
    import vove_pkg::*;

    // a waiting input beat keeps its payload
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_ball_x) && $stable(s_ball_y))
        else $error("input beat changed while waiting");

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_vel_x) && $stable(m_vel_y)
                                && $stable(m_points_used))
        else $error("result beat changed while stalled");

    // one beat in flight: the block is busy right after taking a beat
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken on consecutive cycles");

    // fewer than two points cannot give a velocity
    a_zero_vel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_points_used == 3'd0 || m_points_used == 3'd1)
            |-> m_vel_x == '0 && m_vel_y == '0)
        else $error("non-zero velocity from fewer than two points");

    a_points: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_points_used <= CNT_W'(HISTORY_DEPTH))
        else $error("points_used beyond history depth");

endmodule

bind variable_order_velocity_estimator vove_chk #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .POSITION_BITS (POSITION_BITS)
) u_vove_chk (.*);
